### src/ssrm_pkg.sv
// Package for the serial sensor register master.
// Holds the command codes, register indexes, phase encoding, and the state,
// configuration and result records. It depends on nothing else.
`default_nettype none

package ssrm_pkg;

   // Command codes carried by the kind field of an input item
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_POLL  = 2'd3;

   // Steps of a motion poll
   localparam logic [1:0] STAGE_ID     = 2'd0;
   localparam logic [1:0] STAGE_MOTION = 2'd1;
   localparam logic [1:0] STAGE_DX     = 2'd2;
   localparam logic [1:0] STAGE_DY     = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BIT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_GAP  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_ADDR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_ID    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOT_ADDR  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOT_MASK  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DX_ADDR   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DY_ADDR   = 3'd7;

   localparam int unsigned BITS_PER_BYTE = 8;

   typedef enum logic [10:0] {
      PH_IDLE    = 11'b000_0000_0001,
      PH_SETUP   = 11'b000_0000_0010,
      PH_ADDR_LO = 11'b000_0000_0100,
      PH_ADDR_HI = 11'b000_0000_1000,
      PH_GAP     = 11'b000_0001_0000,
      PH_DATA_LO = 11'b000_0010_0000,
      PH_DATA_HI = 11'b000_0100_0000,
      PH_IN_LO   = 11'b000_1000_0000,
      PH_IN_HI   = 11'b001_0000_0000,
      PH_FINAL   = 11'b010_0000_0000,
      PH_PGAP    = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [15:0] half_bit_ticks;
      logic [15:0] byte_gap_ticks;
      logic [6:0]  id_reg_addr;
      logic [7:0]  expected_id;
      logic [6:0]  motion_reg_addr;
      logic [7:0]  motion_flag_mask;
      logic [6:0]  delta_x_addr;
      logic [6:0]  delta_y_addr;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] wait_count;
      logic [3:0]  bit_count;
      logic [7:0]  shift_reg;
      logic [7:0]  second_byte;
      logic [1:0]  op_kind;
      logic [1:0]  poll_stage;
      logic [7:0]  captured_byte;
      logic [7:0]  x_hold;
      logic [7:0]  y_hold;
      logic        sclk;
      logic        mosi;
      logic        ss_n;
   } state_type;

   typedef struct packed {
      logic       sclk;
      logic       mosi;
      logic       ss_n;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic [7:0] delta_x;
      logic [7:0] delta_y;
   } result_type;

   // A programmed wait of zero behaves as one tick
   function automatic logic [15:0] ticks_of(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

endpackage

`default_nettype wire

### src/ssrm_if.sv
// Handshake channels of the serial sensor register master.
// ssrm_req_if carries tick items in, ssrm_rsp_if carries result items out.
// Both depend on nothing but their own field widths.
`default_nettype none

interface ssrm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [6:0] addr;
   logic [7:0] wdata;
   logic       miso;

   modport source (output valid, kind, addr, wdata, miso, input ready);
   modport sink   (input valid, kind, addr, wdata, miso, output ready);
endinterface

interface ssrm_rsp_if;
   logic       valid;
   logic       ready;
   logic       sclk;
   logic       mosi;
   logic       ss_n;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic [7:0] delta_x;
   logic [7:0] delta_y;

   modport source (output valid, sclk, mosi, ss_n, busy_res, done_res, read_data,
                   delta_x, delta_y, input ready);
   modport sink   (input valid, sclk, mosi, ss_n, busy_res, done_res, read_data,
                   delta_x, delta_y, output ready);
endinterface

`default_nettype wire

### src/ssrm_csr.sv
// Configuration register file of the serial sensor register master.
// Uses ssrm_pkg for the register indexes and the cfg_type record.
`default_nettype none

module ssrm_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [ssrm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ssrm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output      ssrm_pkg::cfg_type                 cfg
);
   import ssrm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_BIT: cfg_in.half_bit_ticks   = csr_wdata;
            CSR_BYTE_GAP: cfg_in.byte_gap_ticks   = csr_wdata;
            CSR_ID_ADDR:  cfg_in.id_reg_addr      = csr_wdata[6:0];
            CSR_EXP_ID:   cfg_in.expected_id      = csr_wdata[7:0];
            CSR_MOT_ADDR: cfg_in.motion_reg_addr  = csr_wdata[6:0];
            CSR_MOT_MASK: cfg_in.motion_flag_mask = csr_wdata[7:0];
            CSR_DX_ADDR:  cfg_in.delta_x_addr     = csr_wdata[6:0];
            CSR_DY_ADDR:  cfg_in.delta_y_addr     = csr_wdata[6:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_ticks   <= 16'd2;
         cfg_ff.byte_gap_ticks   <= 16'd10;
         cfg_ff.id_reg_addr      <= 7'd0;
         cfg_ff.expected_id      <= 8'd0;
         cfg_ff.motion_reg_addr  <= 7'd2;
         cfg_ff.motion_flag_mask <= 8'd128;
         cfg_ff.delta_x_addr     <= 7'd3;
         cfg_ff.delta_y_addr     <= 7'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/ssrm_step.sv
// Per-tick next-state logic of the serial sensor register master.
// Pure combinational: one tick item plus the current state gives the next
// state and the result item. Uses ssrm_pkg.
`default_nettype none

module ssrm_step #(
   parameter int unsigned POLL_GAP_TICKS = 30
) (
   input  wire ssrm_pkg::state_type  cur,
   input  wire ssrm_pkg::cfg_type    cfg,
   input  wire logic [1:0]           kind,
   input  wire logic [6:0]           addr,
   input  wire logic [7:0]           wdata,
   input  wire logic                 miso,
   output      ssrm_pkg::state_type  nxt,
   output      ssrm_pkg::result_type res
);
   import ssrm_pkg::*;

   localparam logic [15:0] PollGap = 16'(POLL_GAP_TICKS);

   logic        start;
   logic [7:0]  start_byte;
   logic        done;
   logic [3:0]  bit_inc;
   logic [7:0]  shift_in;
   logic [15:0] half_ticks;

   assign bit_inc    = cur.bit_count + 4'd1;
   assign shift_in   = {cur.shift_reg[6:0], miso};
   assign half_ticks = ticks_of(cfg.half_bit_ticks);

   always_comb begin
      nxt        = cur;
      start      = 1'b0;
      start_byte = 8'd0;
      done       = 1'b0;

      if (cur.phase == PH_IDLE) begin
         unique case (kind)
            KIND_TICK: begin
            end
            KIND_WRITE: begin
               start           = 1'b1;
               start_byte      = {1'b1, addr};
               nxt.second_byte = wdata;
            end
            KIND_READ: begin
               start      = 1'b1;
               start_byte = {1'b0, addr};
            end
            KIND_POLL: begin
               start      = 1'b1;
               start_byte = {1'b0, cfg.id_reg_addr};
            end
         endcase
         if (start) begin
            nxt.op_kind    = kind;
            nxt.poll_stage = STAGE_ID;
         end
      end else if (cur.wait_count > 16'd1) begin
         nxt.wait_count = cur.wait_count - 16'd1;
      end else begin
         nxt.wait_count = 16'd0;
         unique case (cur.phase)
            PH_SETUP: begin
               nxt.phase      = PH_ADDR_LO;
               nxt.wait_count = half_ticks;
            end
            PH_ADDR_LO, PH_DATA_LO: begin
               nxt.sclk       = 1'b0;
               nxt.mosi       = cur.shift_reg[7];
               nxt.shift_reg  = {cur.shift_reg[6:0], 1'b0};
               nxt.phase      = (cur.phase == PH_ADDR_LO) ? PH_ADDR_HI : PH_DATA_HI;
               nxt.wait_count = half_ticks;
            end
            PH_ADDR_HI, PH_DATA_HI: begin
               nxt.sclk      = 1'b1;
               nxt.bit_count = bit_inc;
               priority if (bit_inc < 4'(BITS_PER_BYTE)) begin
                  nxt.phase      = (cur.phase == PH_ADDR_HI) ? PH_ADDR_LO : PH_DATA_LO;
                  nxt.wait_count = half_ticks;
               end else if (cur.phase == PH_ADDR_HI) begin
                  nxt.phase      = PH_GAP;
                  nxt.wait_count = ticks_of(cfg.byte_gap_ticks);
               end else begin
                  nxt.phase      = PH_FINAL;
                  nxt.wait_count = half_ticks;
               end
            end
            PH_GAP: begin
               nxt.bit_count  = 4'd0;
               nxt.wait_count = half_ticks;
               if (cur.op_kind == KIND_WRITE) begin
                  nxt.shift_reg = cur.second_byte;
                  nxt.phase     = PH_DATA_LO;
               end else begin
                  nxt.mosi      = 1'b1;
                  nxt.shift_reg = 8'd0;
                  nxt.phase     = PH_IN_LO;
               end
            end
            PH_IN_LO: begin
               nxt.sclk       = 1'b0;
               nxt.phase      = PH_IN_HI;
               nxt.wait_count = half_ticks;
            end
            PH_IN_HI: begin
               nxt.sclk       = 1'b1;
               nxt.shift_reg  = shift_in;
               nxt.bit_count  = bit_inc;
               nxt.wait_count = half_ticks;
               if (bit_inc < 4'(BITS_PER_BYTE)) begin
                  nxt.phase = PH_IN_LO;
               end else begin
                  nxt.captured_byte = shift_in;
                  nxt.phase         = PH_FINAL;
               end
            end
            PH_FINAL: begin
               nxt.mosi = 1'b1;
               nxt.ss_n = 1'b1;
               priority if (cur.op_kind != KIND_POLL) begin
                  nxt.phase = PH_IDLE;
                  done      = 1'b1;
               end else if ((cur.poll_stage == STAGE_ID &&
                             cur.captured_byte != cfg.expected_id) ||
                            (cur.poll_stage == STAGE_MOTION &&
                             (cur.captured_byte & cfg.motion_flag_mask) == 8'd0)) begin
                  // no sensor or no new motion: report zero deltas
                  nxt.x_hold = 8'd0;
                  nxt.y_hold = 8'd0;
                  nxt.phase  = PH_IDLE;
                  done       = 1'b1;
               end else if (cur.poll_stage == STAGE_DY) begin
                  nxt.y_hold = cur.captured_byte;
                  nxt.phase  = PH_IDLE;
                  done       = 1'b1;
               end else begin
                  if (cur.poll_stage == STAGE_DX) begin
                     nxt.x_hold = cur.captured_byte;
                  end
                  nxt.poll_stage = cur.poll_stage + 2'd1;
                  nxt.phase      = PH_PGAP;
                  nxt.wait_count = ticks_of(PollGap);
               end
            end
            PH_PGAP: begin
               start = 1'b1;
               unique case (cur.poll_stage)
                  STAGE_MOTION: start_byte = {1'b0, cfg.motion_reg_addr};
                  STAGE_DX:     start_byte = {1'b0, cfg.delta_x_addr};
                  STAGE_DY:     start_byte = {1'b0, cfg.delta_y_addr};
                  STAGE_ID:     start_byte = {1'b0, cfg.id_reg_addr};
               endcase
            end
            default: nxt.phase = PH_IDLE;
         endcase
      end

      // open a transfer: select low, then the setup wait
      if (start) begin
         nxt.shift_reg  = start_byte;
         nxt.bit_count  = 4'd0;
         nxt.ss_n       = 1'b0;
         nxt.phase      = PH_SETUP;
         nxt.wait_count = half_ticks;
      end
   end

   always_comb begin
      res.sclk      = nxt.sclk;
      res.mosi      = nxt.mosi;
      res.ss_n      = nxt.ss_n;
      res.busy_res  = (nxt.phase != PH_IDLE);
      res.done_res  = done;
      res.read_data = nxt.captured_byte;
      res.delta_x   = nxt.x_hold;
      res.delta_y   = nxt.y_hold;
   end

endmodule

`default_nettype wire

### src/serial_sensor_register_master.sv
// Serial sensor register master: bit-level serial bus master for the register
// port of an optical motion sensor. Uses ssrm_pkg, ssrm_if, ssrm_csr, ssrm_step.
//
// Every req item is one time tick: kind selects nothing, a register write, a
// register read or a motion poll (ignored while busy_res is high), addr and
// wdata give the target, miso is the sampled sensor data-out line. Every
// accepted item yields exactly one rsp item with the pin levels after that
// tick (sclk, mosi, ss_n), busy_res, a done_res pulse on the completing tick,
// the last read byte and the deltas of the last poll.
// Registers on the csr_ port set the clock half period, the gap between
// bytes and the addresses used by a poll; write them only while idle.
// Results are registered; one item per cycle is sustained while rsp is ready,
// set by the single next-state step and result register.
// A result register plus a one-entry skid buffer sit on the output, so one
// more item is taken while a result is stalled; req ready drops only when
// both hold data, and rises again the cycle after rsp takes one.
// Synchronous reset returns to idle with all pins high, restores the
// register defaults and empties the output buffer; no item is taken in reset.
`default_nettype none

module serial_sensor_register_master #(
   parameter int unsigned POLL_GAP_TICKS = 30
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ssrm_req_if.sink                               req_chan,
   ssrm_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [ssrm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ssrm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ssrm_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   result_type out_ff;
   result_type out_in;
   result_type skid_ff;
   result_type skid_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   logic       accept;
   logic       take;

   ssrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssrm_step #(
      .POLL_GAP_TICKS (POLL_GAP_TICKS)
   ) u_step (
      .cur   (state_ff),
      .cfg   (cfg),
      .kind  (req_chan.kind),
      .addr  (req_chan.addr),
      .wdata (req_chan.wdata),
      .miso  (req_chan.miso),
      .nxt   (state_in),
      .res   (step_res)
   );

   assign req_chan.ready = !skid_valid_ff && !reset;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take           = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            // refill from the skid stage; no accept can happen here
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = step_res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = step_res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = step_res;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_IDLE;
         state_ff.wait_count    <= 16'd0;
         state_ff.bit_count     <= 4'd0;
         state_ff.shift_reg     <= 8'd0;
         state_ff.second_byte   <= 8'd0;
         state_ff.op_kind       <= KIND_TICK;
         state_ff.poll_stage    <= STAGE_ID;
         state_ff.captured_byte <= 8'd0;
         state_ff.x_hold        <= 8'd0;
         state_ff.y_hold        <= 8'd0;
         state_ff.sclk          <= 1'b1;
         state_ff.mosi          <= 1'b1;
         state_ff.ss_n          <= 1'b1;
         out_valid_ff           <= 1'b0;
         skid_valid_ff          <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.sclk      = out_ff.sclk;
   assign rsp_chan.mosi      = out_ff.mosi;
   assign rsp_chan.ss_n      = out_ff.ss_n;
   assign rsp_chan.busy_res  = out_ff.busy_res;
   assign rsp_chan.done_res  = out_ff.done_res;
   assign rsp_chan.read_data = out_ff.read_data;
   assign rsp_chan.delta_x   = out_ff.delta_x;
   assign rsp_chan.delta_y   = out_ff.delta_y;

endmodule

`default_nettype wire

### src/ssrm_checker.sv
// Port-level checks for the serial sensor register master, bound to the
// top level. Sees only the channel signals; depends on nothing else.
`default_nettype none

module ssrm_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_sclk,
   input wire logic       rsp_mosi,
   input wire logic       rsp_ss_n,
   input wire logic       rsp_busy,
   input wire logic       rsp_done,
   input wire logic [7:0] rsp_read_data
);

   // back-pressure only when a result is already waiting
   a_ready_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req ready low with no result pending");

   // every accepted item leaves a result pending on the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted item produced no result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_done)))
      else $error("stalled result changed");

   // an operation ends with the bus released
   a_done_releases_bus: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done) |-> (!rsp_busy && rsp_ss_n && rsp_mosi && rsp_sclk))
      else $error("operation completed with bus not idle");

   a_idle_pins_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy) |-> (rsp_ss_n && rsp_mosi && rsp_sclk))
      else $error("pins not idle while not busy");

endmodule

bind serial_sensor_register_master ssrm_port_checker u_ssrm_port_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_sclk      (rsp_chan.sclk),
   .rsp_mosi      (rsp_chan.mosi),
   .rsp_ss_n      (rsp_chan.ss_n),
   .rsp_busy      (rsp_chan.busy_res),
   .rsp_done      (rsp_chan.done_res),
   .rsp_read_data (rsp_chan.read_data)
);

`default_nettype wire

### dv/ssrm_checker.sv
// Result checker for the serial sensor register master.
// Watches the req, rsp and csr ports, predicts the pin levels and captured bytes of
// every tick item, and compares each rsp item. Uses ssrm_pkg and the channels in ssrm_if.
module ssrm_checker #(
   parameter int unsigned POLL_GAP_TICKS = 30
) (
   input  logic                             clock,
   input  logic                             reset,
   ssrm_req_if                              req_mon,
   ssrm_rsp_if                              rsp_mon,
   input  logic                             csr_we,
   input  logic [ssrm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssrm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                      mismatches,
   output int unsigned                      outstanding
);
   import ssrm_pkg::*;

   cfg_type     regs;
   phase_type   phase_now;
   logic [15:0] ticks_left;
   logic [3:0]  bits_moved;
   logic [7:0]  shifter;
   logic [7:0]  data_byte;
   logic [1:0]  op_now;
   logic [1:0]  poll_step;
   logic [7:0]  last_byte;
   logic [7:0]  x_latch;
   logic [7:0]  y_latch;
   logic        sclk_pin;
   logic        mosi_pin;
   logic        ss_pin;

   result_type  pin_results_due[$];

   function automatic void restore_defaults();
      regs.half_bit_ticks   = 16'd2;
      regs.byte_gap_ticks   = 16'd10;
      regs.id_reg_addr      = 7'd0;
      regs.expected_id      = 8'd0;
      regs.motion_reg_addr  = 7'd2;
      regs.motion_flag_mask = 8'h80;
      regs.delta_x_addr     = 7'd3;
      regs.delta_y_addr     = 7'd4;
      phase_now  = PH_IDLE;
      ticks_left = 16'd0;
      bits_moved = 4'd0;
      shifter    = 8'd0;
      data_byte  = 8'd0;
      op_now     = KIND_TICK;
      poll_step  = STAGE_ID;
      last_byte  = 8'd0;
      x_latch    = 8'd0;
      y_latch    = 8'd0;
      sclk_pin   = 1'b1;
      mosi_pin   = 1'b1;
      ss_pin     = 1'b1;
   endfunction

   function automatic void load_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_HALF_BIT: regs.half_bit_ticks   = val;
         CSR_BYTE_GAP: regs.byte_gap_ticks   = val;
         CSR_ID_ADDR:  regs.id_reg_addr      = val[6:0];
         CSR_EXP_ID:   regs.expected_id      = val[7:0];
         CSR_MOT_ADDR: regs.motion_reg_addr  = val[6:0];
         CSR_MOT_MASK: regs.motion_flag_mask = val[7:0];
         CSR_DX_ADDR:  regs.delta_x_addr     = val[6:0];
         default:      regs.delta_y_addr     = val[6:0];
      endcase
   endfunction

   // a programmed length of zero still waits one tick
   function automatic void arm_wait(phase_type nxt, logic [15:0] n);
      phase_now  = nxt;
      ticks_left = (n == 16'd0) ? 16'd1 : n;
   endfunction

   function automatic void open_frame(logic [7:0] first);
      shifter    = first;
      bits_moved = 4'd0;
      ss_pin     = 1'b0;
      arm_wait(PH_SETUP, regs.half_bit_ticks);
   endfunction

   function automatic logic [6:0] poll_target();
      case (poll_step)
         STAGE_MOTION: return regs.motion_reg_addr;
         STAGE_DX:     return regs.delta_x_addr;
         STAGE_DY:     return regs.delta_y_addr;
         default:      return regs.id_reg_addr;
      endcase
   endfunction

   // returns 1 when the whole operation is over
   function automatic logic close_frame();
      if (op_now != KIND_POLL) begin
         phase_now = PH_IDLE;
         return 1'b1;
      end
      if ((poll_step == STAGE_ID && last_byte != regs.expected_id) ||
          (poll_step == STAGE_MOTION && (last_byte & regs.motion_flag_mask) == 8'd0)) begin
         x_latch   = 8'd0;
         y_latch   = 8'd0;
         phase_now = PH_IDLE;
         return 1'b1;
      end
      if (poll_step == STAGE_DX) begin
         x_latch = last_byte;
      end
      if (poll_step == STAGE_DY) begin
         y_latch   = last_byte;
         phase_now = PH_IDLE;
         return 1'b1;
      end
      poll_step = poll_step + 2'd1;
      arm_wait(PH_PGAP, 16'(POLL_GAP_TICKS));
      return 1'b0;
   endfunction

   function automatic logic wait_expired(logic miso);
      logic fin;
      fin = 1'b0;
      case (phase_now)
         PH_SETUP: arm_wait(PH_ADDR_LO, regs.half_bit_ticks);
         PH_ADDR_LO, PH_DATA_LO: begin
            sclk_pin = 1'b0;
            mosi_pin = shifter[7];
            shifter  = {shifter[6:0], 1'b0};
            if (phase_now == PH_ADDR_LO) begin
               arm_wait(PH_ADDR_HI, regs.half_bit_ticks);
            end else begin
               arm_wait(PH_DATA_HI, regs.half_bit_ticks);
            end
         end
         PH_ADDR_HI, PH_DATA_HI: begin
            sclk_pin   = 1'b1;
            bits_moved = bits_moved + 4'd1;
            if (bits_moved < BITS_PER_BYTE) begin
               if (phase_now == PH_ADDR_HI) begin
                  arm_wait(PH_ADDR_LO, regs.half_bit_ticks);
               end else begin
                  arm_wait(PH_DATA_LO, regs.half_bit_ticks);
               end
            end else if (phase_now == PH_ADDR_HI) begin
               arm_wait(PH_GAP, regs.byte_gap_ticks);
            end else begin
               arm_wait(PH_FINAL, regs.half_bit_ticks);
            end
         end
         PH_GAP: begin
            bits_moved = 4'd0;
            if (op_now == KIND_WRITE) begin
               shifter = data_byte;
               arm_wait(PH_DATA_LO, regs.half_bit_ticks);
            end else begin
               mosi_pin = 1'b1;
               shifter  = 8'd0;
               arm_wait(PH_IN_LO, regs.half_bit_ticks);
            end
         end
         PH_IN_LO: begin
            sclk_pin = 1'b0;
            arm_wait(PH_IN_HI, regs.half_bit_ticks);
         end
         PH_IN_HI: begin
            sclk_pin   = 1'b1;
            shifter    = {shifter[6:0], miso};
            bits_moved = bits_moved + 4'd1;
            if (bits_moved < BITS_PER_BYTE) begin
               arm_wait(PH_IN_LO, regs.half_bit_ticks);
            end else begin
               last_byte = shifter;
               arm_wait(PH_FINAL, regs.half_bit_ticks);
            end
         end
         PH_FINAL: begin
            mosi_pin = 1'b1;
            ss_pin   = 1'b1;
            fin      = close_frame();
         end
         PH_PGAP: open_frame({1'b0, poll_target()});
         default: phase_now = PH_IDLE;
      endcase
      return fin;
   endfunction

   function automatic result_type advance_tick(logic [1:0] kind, logic [6:0] addr,
                                               logic [7:0] wdata, logic miso);
      result_type r;
      logic       fin;
      fin = 1'b0;
      if (phase_now == PH_IDLE) begin
         if (kind != KIND_TICK) begin
            op_now    = kind;
            poll_step = STAGE_ID;
            case (kind)
               KIND_WRITE: begin
                  data_byte = wdata;
                  open_frame({1'b1, addr});
               end
               KIND_READ: open_frame({1'b0, addr});
               default:   open_frame({1'b0, regs.id_reg_addr});
            endcase
         end
      end else if (ticks_left > 16'd1) begin
         ticks_left = ticks_left - 16'd1;
      end else begin
         ticks_left = 16'd0;
         fin        = wait_expired(miso);
      end
      r.sclk      = sclk_pin;
      r.mosi      = mosi_pin;
      r.ss_n      = ss_pin;
      r.busy_res  = (phase_now != PH_IDLE);
      r.done_res  = fin;
      r.read_data = last_byte;
      r.delta_x   = x_latch;
      r.delta_y   = y_latch;
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t rsp %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         restore_defaults();
         pin_results_due.delete();
      end else begin
         if (csr_we) begin
            load_reg(csr_index, csr_wdata);
         end
         // rsp lags req by the result register, so compare before predicting
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pin_results_due.size() == 0) begin
               mismatches++;
               $display("%0t unexpected rsp item, nothing predicted", $time);
            end else begin
               want = pin_results_due.pop_front();
               check_field("sclk", 8'(want.sclk), 8'(rsp_mon.sclk));
               check_field("mosi", 8'(want.mosi), 8'(rsp_mon.mosi));
               check_field("ss_n", 8'(want.ss_n), 8'(rsp_mon.ss_n));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_mon.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_mon.done_res));
               check_field("read_data", want.read_data, rsp_mon.read_data);
               check_field("delta_x", want.delta_x, rsp_mon.delta_x);
               check_field("delta_y", want.delta_y, rsp_mon.delta_y);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pin_results_due.push_back(advance_tick(req_mon.kind, req_mon.addr,
                                                   req_mon.wdata, req_mon.miso));
         end
      end
      outstanding = pin_results_due.size();
   end

endmodule

### dv/tb_serial_sensor_register_master.sv
// Testbench top for the serial sensor register master.
// Drives tick items with a scripted sensor data-out line, programs the csr port between
// runs and gives the verdict. Uses ssrm_pkg, ssrm_if and ssrm_checker.
module tb_serial_sensor_register_master;
   import ssrm_pkg::*;

   localparam int unsigned POLL_GAP     = 30;
   localparam int unsigned CYCLE_LIMIT  = 50_000;
   localparam int unsigned SEGMENTS     = 4;
   localparam int unsigned OPS_PER_SEG  = 2;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            mismatches;
   int unsigned            outstanding;
   int unsigned            cycles = 0;
   int unsigned            idle_pct = 0;
   int unsigned            stall_pct = 0;
   int unsigned            noise_pct = 25;

   // copy of the programmed values that shape the sensor reply timing and frame count
   logic [15:0]            half_set = 16'd2;
   logic [15:0]            gap_set = 16'd10;
   logic [7:0]             id_want = 8'd0;
   logic [7:0]             flag_mask = 8'h80;

   ssrm_req_if req_bus();
   ssrm_rsp_if rsp_bus();

   serial_sensor_register_master #(.POLL_GAP_TICKS(POLL_GAP)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ssrm_checker #(.POLL_GAP_TICKS(POLL_GAP)) watch (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_serial_sensor_register_master: done, errors");
         $finish;
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic put_item(logic [1:0] kind, logic [6:0] addr, logic [7:0] wdata, logic miso);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.addr  <= addr;
      req_bus.wdata <= wdata;
      req_bus.miso  <= miso;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // commands sent while busy must be dropped by the block
   task automatic put_tick(logic miso);
      logic [1:0] kind;
      kind = ($urandom_range(0, 99) < noise_pct) ? 2'($urandom_range(1, 3)) : KIND_TICK;
      put_item(kind, 7'($urandom), 8'($urandom), miso);
   endtask

   task automatic put_idle_ticks(int unsigned n);
      repeat (n) put_item(KIND_TICK, 7'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // Send the command, then every tick up to and including the completing one.
   // The data-out line carries the reply bytes on the ticks where they are sampled.
   task automatic run_op(logic [1:0] kind, logic [6:0] addr, logic [7:0] wdata,
                         logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
      logic [7:0]  reply [4];
      int unsigned frames;
      int unsigned h;
      int unsigned g;
      int unsigned span;
      int unsigned first_sample;
      int unsigned slot;
      reply[0] = b0;
      reply[1] = b1;
      reply[2] = b2;
      reply[3] = b3;
      h = (half_set == 16'd0) ? 1 : half_set;
      g = (gap_set == 16'd0) ? 1 : gap_set;
      span = 34 * h + g;
      first_sample = 19 * h + g;
      frames = 1;
      if (kind == KIND_POLL) begin
         if (b0 != id_want) begin
            frames = 1;
         end else if ((b1 & flag_mask) == 8'd0) begin
            frames = 2;
         end else begin
            frames = 4;
         end
      end
      put_item(kind, addr, wdata, 1'($urandom));
      for (int f = 0; f < frames; f++) begin
         // the last gap tick opens the next frame
         if (f > 0) begin
            repeat (POLL_GAP) put_tick(1'($urandom));
         end
         for (int unsigned t = 1; t <= span; t++) begin
            slot = (t >= first_sample) ? (t - first_sample) / (2 * h) : 8;
            if (t >= first_sample && (t - first_sample) % (2 * h) == 0 && slot < 8) begin
               put_tick(reply[f][7 - slot]);
            end else begin
               put_tick(1'($urandom));
            end
         end
      end
   endtask

   task automatic random_op();
      logic [1:0] kind;
      logic [7:0] first;
      logic [7:0] status;
      logic [7:0] low_flag;
      kind = 2'($urandom_range(1, 3));
      first = 8'($urandom);
      if (kind == KIND_POLL && $urandom_range(0, 3) != 0) begin
         first = id_want;
      end
      status = 8'($urandom);
      low_flag = flag_mask & (~flag_mask + 8'd1);
      if ($urandom_range(0, 3) != 0) begin
         status = status | low_flag;
      end else begin
         status = status & ~flag_mask;
      end
      if ($urandom_range(0, 4) == 0) begin
         put_idle_ticks($urandom_range(1, 4));
      end
      run_op(kind, 7'($urandom), 8'($urandom), first, status, 8'($urandom), 8'($urandom));
   endtask

   // call only with the block idle; drop csr_we after the last write of a batch
   task automatic set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HALF_BIT: half_set = val;
         CSR_BYTE_GAP: gap_set = val;
         CSR_EXP_ID:   id_want = val[7:0];
         CSR_MOT_MASK: flag_mask = val[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // hold off new items until every rsp item has been checked
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= CSR_HALF_BIT;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_TICK;
      req_bus.addr  <= '0;
      req_bus.wdata <= '0;
      req_bus.miso  <= 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: a poll that finds the wrong identifier
      put_idle_ticks(3);
      run_op(KIND_POLL, 7'h7F, 8'hFF, 8'hA5, 8'h80, 8'h11, 8'h22);

      // zero lengths, far ends of the addresses and masks
      drain();
      set_reg(CSR_HALF_BIT, 16'd0);
      set_reg(CSR_BYTE_GAP, 16'd0);
      set_reg(CSR_ID_ADDR, 16'd127);
      set_reg(CSR_EXP_ID, 16'd255);
      set_reg(CSR_MOT_ADDR, 16'd0);
      set_reg(CSR_MOT_MASK, 16'hFF);
      set_reg(CSR_DX_ADDR, 16'd127);
      set_reg(CSR_DY_ADDR, 16'd0);
      csr_we <= 1'b0;
      run_op(KIND_POLL, 7'h00, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         case (seg % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 83;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 83;
            end
            default: begin
               idle_pct  = 28;
               stall_pct = 28;
            end
         endcase
         set_reg(CSR_HALF_BIT, 16'($urandom_range(0, 1)));
         set_reg(CSR_BYTE_GAP, 16'($urandom_range(0, 2)));
         set_reg(CSR_ID_ADDR, 16'($urandom_range(0, 127)));
         set_reg(CSR_EXP_ID, 16'($urandom_range(0, 255)));
         set_reg(CSR_MOT_ADDR, 16'($urandom_range(0, 127)));
         set_reg(CSR_MOT_MASK, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 255)));
         set_reg(CSR_DX_ADDR, 16'($urandom_range(0, 127)));
         set_reg(CSR_DY_ADDR, 16'($urandom_range(0, 127)));
         csr_we <= 1'b0;
         repeat (OPS_PER_SEG) random_op();
      end

      drain();
      if (mismatches == 0) begin
         $display("tb_serial_sensor_register_master: done, clean");
      end else begin
         $display("tb_serial_sensor_register_master: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
src/ssrm_pkg.sv
src/ssrm_if.sv
src/ssrm_csr.sv
src/ssrm_step.sv
src/serial_sensor_register_master.sv
src/ssrm_checker.sv
dv/ssrm_checker.sv
dv/tb_serial_sensor_register_master.sv
